>>> rtl/lsp_pkg.sv
`timescale 1ns / 1ps

package lsp_pkg;

   localparam int NumChan = 6;

   typedef logic [7:0]  sample_type;
   typedef logic [8:0]  pos_type;
   typedef logic [2:0]  chan_type;

   // Command codes carried in the request.
   localparam logic [1:0] CmdClear   = 2'd0;
   localparam logic [1:0] CmdCalib   = 2'd1;
   localparam logic [1:0] CmdMeasure = 2'd2;

   // Control register indexes.
   localparam logic [2:0] CsrNoiseFloor = 3'd0;
   localparam logic [2:0] CsrLocOne     = 3'd1;
   localparam logic [2:0] CsrLocTwo     = 3'd2;
   localparam logic [2:0] CsrLocThree   = 3'd3;
   localparam logic [2:0] CsrLocFour    = 3'd4;

   localparam sample_type FullScale   = 8'd255;
   localparam sample_type NoiseReset  = 8'd40;
   localparam pos_type    EdgeWeight  = 9'd500;
   localparam pos_type    MidPosition = 9'd250;
   localparam pos_type    LocOneReset   = 9'd115;
   localparam pos_type    LocTwoReset   = 9'd211;
   localparam pos_type    LocThreeReset = 9'd288;
   localparam pos_type    LocFourReset  = 9'd384;

   localparam chan_type   LastChan = 3'd5;

   // The divider retires two quotient bits per cycle over a 20-bit dividend.
   localparam logic [3:0] DivSteps = 4'd10;

   typedef enum logic [2:0] {
      StIdle,
      StChSetup,
      StChDiv,
      StChAcc,
      StFinSetup,
      StFinDiv,
      StOut
   } state_type;

   typedef struct packed {
      logic clear_cal;
      logic cal_sample;
      logic load_scan;
      logic ch_next;
      logic div_ch_start;
      logic div_fin_start;
      logic div_step;
      logic ch_acc;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic ch_skip;
      logic ch_last;
      logic div_busy;
      logic den_zero;
      logic out_free;
   } dp_status_type;

endpackage

>>> rtl/lsp_ctrl.sv
`timescale 1ns / 1ps

module lsp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic [1:0]            req_command,
   output logic                  req_tready,
   input  lsp_pkg::dp_status_type status,
   output lsp_pkg::dp_cmd_type    cmd
);
   import lsp_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         StIdle: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               unique case (req_command)
                  CmdClear: begin
                     cmd.clear_cal = 1'b1;
                  end
                  CmdCalib: begin
                     cmd.cal_sample = 1'b1;
                  end
                  CmdMeasure: begin
                     cmd.load_scan = 1'b1;
                     state_in      = StChSetup;
                  end
                  default: ;
               endcase
            end
         end
         StChSetup: begin
            // A flat channel or a sample at or below its minimum adds nothing.
            if (status.ch_skip) begin
               if (status.ch_last) begin
                  state_in = StFinSetup;
               end else begin
                  cmd.ch_next = 1'b1;
               end
            end else begin
               cmd.div_ch_start = 1'b1;
               state_in         = StChDiv;
            end
         end
         StChDiv: begin
            if (status.div_busy) begin
               cmd.div_step = 1'b1;
            end else begin
               state_in = StChAcc;
            end
         end
         StChAcc: begin
            cmd.ch_acc = 1'b1;
            if (status.ch_last) begin
               state_in = StFinSetup;
            end else begin
               cmd.ch_next = 1'b1;
               state_in    = StChSetup;
            end
         end
         StFinSetup: begin
            if (status.den_zero) begin
               state_in = StOut;
            end else begin
               cmd.div_fin_start = 1'b1;
               state_in          = StFinDiv;
            end
         end
         StFinDiv: begin
            if (status.div_busy) begin
               cmd.div_step = 1'b1;
            end else begin
               state_in = StOut;
            end
         end
         StOut: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

endmodule

>>> rtl/lsp_dp.sv
`timescale 1ns / 1ps

module lsp_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [2:0]             csr_index,
   input  logic [8:0]             csr_wdata,
   input  logic                   left_edge_hit,
   input  logic                   right_edge_hit,
   input  lsp_pkg::sample_type    sample_one,
   input  lsp_pkg::sample_type    sample_two,
   input  lsp_pkg::sample_type    sample_three,
   input  lsp_pkg::sample_type    sample_four,
   input  lsp_pkg::dp_cmd_type    cmd,
   output lsp_pkg::dp_status_type status,
   input  logic                   rsp_tready,
   output logic                   rsp_tvalid,
   output lsp_pkg::pos_type       rsp_position,
   output logic                   rsp_line_seen
);
   import lsp_pkg::*;

   // Control registers.
   sample_type nf_ff;
   pos_type    loc1_ff;
   pos_type    loc2_ff;
   pos_type    loc3_ff;
   pos_type    loc4_ff;

   // Calibration and scan storage.
   sample_type min_ff  [NumChan];
   sample_type max_ff  [NumChan];
   sample_type scan_ff [NumChan];
   sample_type scan_in [NumChan];
   sample_type min_in  [NumChan];
   sample_type max_in  [NumChan];

   chan_type    ch_ff;
   logic [19:0] num_ff;
   logic [10:0] den_ff;
   pos_type     last_ff;

   // Shared radix-4 restoring divider.
   logic [10:0] rem_ff;
   logic [19:0] quo_ff;
   logic [10:0] dvs_ff;
   logic [3:0]  dcnt_ff;
   logic [10:0] rem_in;
   logic [19:0] quo_in;

   logic        rsp_valid_ff;
   pos_type     pos_out_ff;
   logic        seen_out_ff;

   sample_type  lo;
   sample_type  hi;
   sample_type  v;
   sample_type  diff;
   sample_type  span;
   logic [15:0] ch_dividend;
   pos_type     weight;
   sample_type  s_sat;
   sample_type  s_val;
   logic [16:0] prod;
   logic [19:0] num_in;
   logic [10:0] den_in;
   pos_type     fin_pos;
   pos_type     fallback;
   logic        out_free;

   assign scan_in[0] = left_edge_hit ? FullScale : '0;
   assign scan_in[1] = sample_one;
   assign scan_in[2] = sample_two;
   assign scan_in[3] = sample_three;
   assign scan_in[4] = sample_four;
   assign scan_in[5] = right_edge_hit ? FullScale : '0;

   // A zero minimum or maximum is unset and first takes the sample.
   always_comb begin
      for (int i = 0; i < NumChan; i++) begin
         min_in[i] = (min_ff[i] == '0) ? scan_in[i] : min_ff[i];
         max_in[i] = (max_ff[i] == '0) ? scan_in[i] : max_ff[i];
         if (scan_in[i] < min_in[i]) begin
            min_in[i] = scan_in[i];
         end
         if (scan_in[i] > max_in[i]) begin
            max_in[i] = scan_in[i];
         end
      end
   end

   assign lo   = min_ff[ch_ff];
   assign hi   = max_ff[ch_ff];
   assign v    = scan_ff[ch_ff];
   assign diff = v - lo;
   assign span = hi - lo;
   // Multiply by 255 as a shift and a subtract.
   assign ch_dividend = {diff, 8'd0} - {8'd0, diff};

   always_comb begin
      case (ch_ff)
         3'd1:    weight = loc1_ff;
         3'd2:    weight = loc2_ff;
         3'd3:    weight = loc3_ff;
         3'd4:    weight = loc4_ff;
         3'd5:    weight = EdgeWeight;
         default: weight = '0;
      endcase
   end

   assign s_sat  = (quo_ff[19:8] != '0) ? FullScale : quo_ff[7:0];
   assign s_val  = (s_sat < nf_ff) ? '0 : s_sat;
   assign prod   = weight * s_val;
   assign num_in = num_ff + {3'd0, prod};
   assign den_in = den_ff + {3'd0, s_val};

   assign fin_pos  = (quo_ff > {11'd0, EdgeWeight}) ? EdgeWeight : quo_ff[8:0];
   assign fallback = (last_ff < MidPosition) ? '0 : EdgeWeight;

   // Two restoring steps per cycle.
   always_comb begin
      logic [11:0] r_a;
      logic [11:0] r_b;
      logic        bit_a;
      logic        bit_b;
      r_a   = {rem_ff, quo_ff[19]};
      bit_a = (r_a >= {1'b0, dvs_ff});
      if (bit_a) begin
         r_a = r_a - {1'b0, dvs_ff};
      end
      r_b   = {r_a[10:0], quo_ff[18]};
      bit_b = (r_b >= {1'b0, dvs_ff});
      if (bit_b) begin
         r_b = r_b - {1'b0, dvs_ff};
      end
      rem_in = r_b[10:0];
      quo_in = {quo_ff[17:0], bit_a, bit_b};
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   assign status.ch_skip  = (hi <= lo) || (v <= lo);
   assign status.ch_last  = (ch_ff == LastChan);
   assign status.div_busy = (dcnt_ff != '0);
   assign status.den_zero = (den_ff == '0);
   assign status.out_free = out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         nf_ff   <= NoiseReset;
         loc1_ff <= LocOneReset;
         loc2_ff <= LocTwoReset;
         loc3_ff <= LocThreeReset;
         loc4_ff <= LocFourReset;
      end else if (csr_we) begin
         unique case (csr_index)
            CsrNoiseFloor: nf_ff   <= csr_wdata[7:0];
            CsrLocOne:     loc1_ff <= csr_wdata;
            CsrLocTwo:     loc2_ff <= csr_wdata;
            CsrLocThree:   loc3_ff <= csr_wdata;
            CsrLocFour:    loc4_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumChan; i++) begin
            min_ff[i] <= '0;
            max_ff[i] <= '0;
         end
      end else if (cmd.clear_cal) begin
         for (int i = 0; i < NumChan; i++) begin
            min_ff[i] <= '0;
            max_ff[i] <= '0;
         end
      end else if (cmd.cal_sample) begin
         for (int i = 0; i < NumChan; i++) begin
            min_ff[i] <= min_in[i];
            max_ff[i] <= max_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_scan) begin
         for (int i = 0; i < NumChan; i++) begin
            scan_ff[i] <= scan_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_ff  <= '0;
         num_ff <= '0;
         den_ff <= '0;
      end else if (cmd.load_scan) begin
         ch_ff  <= '0;
         num_ff <= '0;
         den_ff <= '0;
      end else begin
         if (cmd.ch_acc) begin
            num_ff <= num_in;
            den_ff <= den_in;
         end
         if (cmd.ch_next) begin
            ch_ff <= ch_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff <= '0;
      end else if (cmd.div_ch_start || cmd.div_fin_start) begin
         dcnt_ff <= DivSteps;
      end else if (cmd.div_step) begin
         dcnt_ff <= dcnt_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_ch_start) begin
         rem_ff <= '0;
         quo_ff <= {4'd0, ch_dividend};
         dvs_ff <= {3'd0, span};
      end else if (cmd.div_fin_start) begin
         rem_ff <= '0;
         quo_ff <= num_ff;
         dvs_ff <= den_ff;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
      end else if (cmd.out_load && !status.den_zero) begin
         last_ff <= fin_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         pos_out_ff  <= status.den_zero ? fallback : fin_pos;
         seen_out_ff <= !status.den_zero;
      end
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_position  = pos_out_ff;
   assign rsp_line_seen = seen_out_ff;

`ifndef SYNTH
   a_step_needs_count: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (dcnt_ff != '0))
      else $error("divider stepped past its last iteration");

   a_chan_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.ch_acc || cmd.div_ch_start) |-> (ch_ff <= LastChan))
      else $error("channel index out of range");

   a_acc_nonzero_divisor: assert property (@(posedge clock) disable iff (reset)
      cmd.ch_acc |-> (dvs_ff != '0))
      else $error("channel accumulated after a divide by zero span");

   a_load_into_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> out_free)
      else $error("result loaded over a pending result");

   a_no_line_edge: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) && !seen_out_ff |->
         (pos_out_ff == '0 || pos_out_ff == EdgeWeight))
      else $error("no-line result is not at an edge");
`endif

endmodule

>>> rtl/line_sensor_position.sv
`timescale 1ns / 1ps

// Channel    Dir  Handshake              Contents
// req_       in   req_tvalid/req_tready  one scan and its command
// rsp_       out  rsp_tvalid/rsp_tready  position and line flag, measure only
// csr_       in   csr_we                 noise floor and channel weights
//
// Clear and calibration commands are carried out in idle without leaving it.
// A measure walks the channels in turn, skipping a flat or dark one and dividing and
// accumulating an active one, then divides for the position unless no channel is active,
// using the shared two-bits-per-cycle divider that serves all seven divisions in turn.
// Reset clears calibration and last position and loads the control register defaults.
// A pending result does not block a new scan until the next measure finishes.

module line_sensor_position (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [1:0] command, [2] left_edge_hit, [3] right_edge_hit, [11:4] sample_one,
   // [19:12] sample_two, [27:20] sample_three, [35:28] sample_four
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [8:0] position, [9] line_seen
   output logic [15:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [8:0]  csr_wdata
);
   import lsp_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   pos_type       position;
   logic          line_seen;

   lsp_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_command (req_tdata[1:0]),
      .req_tready  (req_tready),
      .status      (status),
      .cmd         (cmd)
   );

   lsp_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .left_edge_hit  (req_tdata[2]),
      .right_edge_hit (req_tdata[3]),
      .sample_one     (req_tdata[11:4]),
      .sample_two     (req_tdata[19:12]),
      .sample_three   (req_tdata[27:20]),
      .sample_four    (req_tdata[35:28]),
      .cmd            (cmd),
      .status         (status),
      .rsp_tready     (rsp_tready),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_position   (position),
      .rsp_line_seen  (line_seen)
   );

   assign rsp_tdata = {6'd0, line_seen, position};

endmodule

>>> sim/line_sensor_position_tb.sv
`timescale 1ns / 1ps

module line_sensor_position_tb;

   import lsp_pkg::*;

   localparam logic [1:0] CmdUnused = 2'd3;
   localparam int CycleLimit = 1000000;
   localparam int SettleCycles = 100;
   localparam int MaxWait = 11;

   typedef struct packed {
      logic [8:0] position;
      logic       line_seen;
   } position_result_type;

   // Tracks calibration and weights and predicts the position of each measure.
   class position_scoreboard;
      logic [7:0] noise_floor;
      logic [8:0] weight [NumChan];
      logic [7:0] cal_min [NumChan];
      logic [7:0] cal_max [NumChan];
      logic [8:0] last_position;
      position_result_type expected_q [$];
      int scans_noted;
      int results_checked;
      int mismatches;

      function new();
         noise_floor = NoiseReset;
         weight[0] = '0;
         weight[1] = LocOneReset;
         weight[2] = LocTwoReset;
         weight[3] = LocThreeReset;
         weight[4] = LocFourReset;
         weight[5] = EdgeWeight;
         foreach (cal_min[i]) begin
            cal_min[i] = '0;
            cal_max[i] = '0;
         end
         last_position = '0;
         scans_noted = 0;
         results_checked = 0;
         mismatches = 0;
      endfunction

      function void set_reg(logic [2:0] index, logic [8:0] value);
         case (index)
            CsrNoiseFloor: noise_floor = value[7:0];
            CsrLocOne:     weight[1] = value;
            CsrLocTwo:     weight[2] = value;
            CsrLocThree:   weight[3] = value;
            CsrLocFour:    weight[4] = value;
            default: ;
         endcase
      endfunction

      function void note_scan(logic [39:0] scan);
         logic [1:0] cmd;
         logic [7:0] v [NumChan];
         int vi, lo, hi, s, num, den, pos;
         position_result_type r;
         cmd = scan[1:0];
         v[0] = scan[2] ? FullScale : 8'd0;
         v[1] = scan[11:4];
         v[2] = scan[19:12];
         v[3] = scan[27:20];
         v[4] = scan[35:28];
         v[5] = scan[3] ? FullScale : 8'd0;
         scans_noted++;
         case (cmd)
            CmdClear: begin
               foreach (cal_min[i]) begin
                  cal_min[i] = '0;
                  cal_max[i] = '0;
               end
            end
            CmdCalib: begin
               // A zero entry is unset and takes the sample before the compare.
               foreach (v[i]) begin
                  if (cal_min[i] == 0) cal_min[i] = v[i];
                  if (cal_max[i] == 0) cal_max[i] = v[i];
                  if (v[i] < cal_min[i]) cal_min[i] = v[i];
                  if (v[i] > cal_max[i]) cal_max[i] = v[i];
               end
            end
            CmdMeasure: begin
               num = 0;
               den = 0;
               foreach (v[i]) begin
                  vi = v[i];
                  lo = cal_min[i];
                  hi = cal_max[i];
                  if (hi <= lo || vi <= lo) begin
                     s = 0;
                  end else begin
                     s = (vi - lo) * 255 / (hi - lo);
                     if (s > 255) s = 255;
                     if (s < int'(noise_floor)) s = 0;
                  end
                  num += int'(weight[i]) * s;
                  den += s;
               end
               if (den != 0) begin
                  pos = num / den;
                  if (pos > int'(EdgeWeight)) pos = EdgeWeight;
                  last_position = pos[8:0];
                  r.line_seen = 1'b1;
               end else begin
                  pos = (last_position < MidPosition) ? 0 : int'(EdgeWeight);
                  r.line_seen = 1'b0;
               end
               r.position = pos[8:0];
               expected_q.push_back(r);
            end
            default: ;
         endcase
      endfunction

      function void check_result(logic [15:0] data);
         position_result_type got, want;
         got.position = data[8:0];
         got.line_seen = data[9];
         results_checked++;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected result position=%0d line_seen=%0b",
                        $realtime, got.position, got.line_seen);
            return;
         end
         want = expected_q.pop_front();
         if (got.position !== want.position || got.line_seen !== want.line_seen) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: expected position=%0d line_seen=%0b, got position=%0d line_seen=%0b",
                        $realtime, want.position, want.line_seen, got.position, got.line_seen);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [8:0]  csr_wdata = '0;

   position_scoreboard sb = new();
   bit no_idle = 1'b0;
   int rx_wait = 0;
   int cycles = 0;
   int phases = 0;

   line_sensor_position dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Verification failed");
         $finish;
      end
   end

   function automatic int draw_wait();
      return no_idle ? 0 : $urandom_range(0, MaxWait);
   endfunction

   // The receiver stalls for a freshly drawn number of cycles after each result.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tdata);
         rx_wait = draw_wait();
         rsp_tready <= (rx_wait == 0);
      end else if (rx_wait != 0) begin
         rx_wait--;
         rsp_tready <= (rx_wait == 0);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [39:0] pack_scan(logic [1:0] cmd, logic left, logic right,
                                             logic [7:0] s1, logic [7:0] s2,
                                             logic [7:0] s3, logic [7:0] s4);
      return {4'b0, s4, s3, s2, s1, right, left, cmd};
   endfunction

   // Scan samples lean toward the ends of the range now and then.
   function automatic logic [7:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [39:0] random_scan(logic [1:0] cmd);
      return pack_scan(cmd, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       pick_sample(), pick_sample(), pick_sample(), pick_sample());
   endfunction

   // A valid that stays high between back-to-back transactions is not lowered.
   task automatic send_scan(input logic [39:0] scan);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= scan;
      do @(posedge clock); while (!req_tready);
      sb.note_scan(scan);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [8:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      sb.set_reg(index, value);
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [7:0] noise, input logic [8:0] w1,
                                 input logic [8:0] w2, input logic [8:0] w3,
                                 input logic [8:0] w4);
      write_reg(CsrNoiseFloor, {1'b0, noise});
      write_reg(CsrLocOne, w1);
      write_reg(CsrLocTwo, w2);
      write_reg(CsrLocThree, w3);
      write_reg(CsrLocFour, w4);
      csr_we <= 1'b0;
      phases++;
   endtask

   task automatic directed_scans();
      // Nothing calibrated yet: every channel is flat.
      send_scan(pack_scan(CmdMeasure, 1, 1, 255, 255, 255, 255));
      send_scan(pack_scan(CmdUnused, 1, 0, 8'h5a, 8'ha5, 8'h0f, 8'hf0));
      // Zero samples leave entries unset; the edge minimums flip between set and unset.
      send_scan(pack_scan(CmdCalib, 0, 0, 0, 0, 0, 0));
      send_scan(pack_scan(CmdCalib, 1, 1, 50, 60, 70, 80));
      send_scan(pack_scan(CmdCalib, 0, 0, 200, 210, 220, 230));
      send_scan(pack_scan(CmdCalib, 1, 1, 20, 30, 40, 50));
      send_scan(pack_scan(CmdCalib, 0, 0, 255, 255, 255, 255));
      send_scan(pack_scan(CmdMeasure, 0, 0, 0, 0, 0, 0));
      send_scan(pack_scan(CmdMeasure, 0, 1, 0, 0, 0, 0));
      // Dark scans after the line was seen on the right report the far end.
      send_scan(pack_scan(CmdMeasure, 0, 0, 0, 0, 0, 0));
      send_scan(pack_scan(CmdMeasure, 1, 0, 0, 0, 0, 0));
      send_scan(pack_scan(CmdMeasure, 0, 0, 20, 30, 40, 50));
      send_scan(pack_scan(CmdMeasure, 0, 0, 21, 31, 41, 51));
      send_scan(pack_scan(CmdMeasure, 1, 1, 255, 255, 255, 255));
      send_scan(pack_scan(CmdMeasure, 0, 0, 0, 150, 0, 0));
      send_scan(pack_scan(CmdUnused, 1, 1, 255, 255, 255, 255));
      send_scan(pack_scan(CmdClear, 1, 1, 255, 255, 255, 255));
      send_scan(pack_scan(CmdMeasure, 1, 1, 200, 200, 200, 200));
      send_scan(pack_scan(CmdCalib, 0, 0, 100, 100, 100, 100));
      send_scan(pack_scan(CmdCalib, 0, 0, 100, 100, 100, 100));
      send_scan(pack_scan(CmdMeasure, 0, 0, 150, 150, 150, 150));
      send_scan(pack_scan(CmdCalib, 0, 0, 90, 95, 99, 1));
      send_scan(pack_scan(CmdMeasure, 0, 0, 255, 96, 0, 255));
   endtask

   task automatic random_scans(input int count);
      int pick;
      if ($urandom_range(0, 2) != 0) begin
         send_scan(random_scan(CmdClear));
         repeat ($urandom_range(2, 6))
            send_scan(pack_scan(CmdCalib, 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)),
                                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))));
      end
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 3)
            send_scan(random_scan(CmdClear));
         else if (pick < 15)
            send_scan(random_scan(CmdCalib));
         else if (pick < 18)
            send_scan(random_scan(CmdUnused));
         else
            send_scan(random_scan(CmdMeasure));
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_scans();

      // Weights above the bar's end saturate the position.
      settle();
      apply_settings(0, 511, 511, 511, 511);
      send_scan(pack_scan(CmdMeasure, 0, 0, 255, 255, 96, 200));
      send_scan(pack_scan(CmdMeasure, 0, 0, 91, 0, 0, 0));
      settle();
      apply_settings(255, 0, 0, 0, 0);
      send_scan(pack_scan(CmdMeasure, 0, 0, 255, 255, 255, 255));
      send_scan(pack_scan(CmdMeasure, 0, 0, 254, 0, 0, 0));

      for (int p = 0; p < 10; p++) begin
         settle();
         case (p)
            0: apply_settings(0, 0, 0, 0, 0);
            1: apply_settings(255, 511, 511, 511, 511);
            2: apply_settings(40, 115, 211, 288, 384);
            default: apply_settings(8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)),
                                    9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                                    9'($urandom_range(0, 511)));
         endcase
         no_idle = (p % 4 == 3);
         random_scans(150);
      end
      no_idle = 1'b0;
      settle();

      $display("Sent %0d scans over %0d register settings, checked %0d positions.",
               sb.scans_noted, phases, sb.results_checked);
      if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches, %0d positions never arrived",
                  sb.mismatches, sb.expected_q.size());
         $display("Verification failed");
      end
      $finish;
   end

endmodule
